// ===== design/cfgack_pkg.sv =====
`timescale 1ns / 1ps
// shared types and codes for the configure/ack tracker
// no dependencies

package cfgack_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int SERIAL_W        = 32;
  localparam int DIM_W           = 15;
  localparam int OPCODE_W        = 2;
  localparam int STATUS_W        = 3;
  localparam int IN_TDATA_W      = 64;
  localparam int IN_TUSER_W      = 3;
  localparam int OUT_TDATA_W     = 96;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CONFIGURE = 2'd0,
    OP_ACK       = 2'd1,
    OP_COMMIT    = 2'd2,
    OP_UNUSED    = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_SERIAL  = 3'd1,
    ST_NULL_BUFFER = 3'd2,
    ST_NOT_ACKED   = 3'd3,
    ST_SIZE_MISM   = 3'd4
  } status_t;

  // queue entry, serial in the low bits
  typedef struct packed {
    logic [DIM_W-1:0]    height;
    logic [DIM_W-1:0]    width;
    logic [SERIAL_W-1:0] serial;
  } entry_t;

  typedef struct packed {
    logic                push;
    logic                search;
    entry_t              entry;
  } q_req_t;

  typedef struct packed {
    logic                done;
    logic                hit;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
  } q_rsp_t;

  // result tdata, sent_serial in the low bits
  typedef struct packed {
    logic [DIM_W-1:0]    acked_h;
    logic [DIM_W-1:0]    acked_w;
    logic                is_configured;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    sent_height;
    logic [DIM_W-1:0]    sent_width;
    logic [SERIAL_W-1:0] sent_serial;
  } out_data_t;

endpackage

// ===== design/cfgack_queue.sv =====
`timescale 1ns / 1ps
// pending configure queue: circular memory with a serial search sequencer
// depends on cfgack_pkg

module cfgack_queue #(
  parameter int DEPTH = cfgack_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfgack_pkg::q_req_t req,
  output cfgack_pkg::q_rsp_t rsp
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    Q_IDLE  = 3'b001,
    Q_FETCH = 3'b010,
    Q_SCAN  = 3'b100
  } q_state_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  cfgack_pkg::entry_t mem [DEPTH];
  cfgack_pkg::entry_t rd_data_r;

  q_state_t                          state_r, state_nxt;
  logic [PTR_W-1:0]                  head_r, head_nxt;
  logic [PTR_W-1:0]                  tail_r, tail_nxt;
  logic [PTR_W-1:0]                  scan_ptr_r, scan_ptr_nxt;
  logic [PTR_W-1:0]                  k_r, k_nxt;
  logic [CNT_W-1:0]                  count_r, count_nxt;
  logic [cfgack_pkg::SERIAL_W-1:0]   serial_r;
  logic                              done_r, done_nxt;
  logic                              hit_r, hit_nxt;
  logic [cfgack_pkg::DIM_W-1:0]      hit_w_r, hit_w_nxt;
  logic [cfgack_pkg::DIM_W-1:0]      hit_h_r, hit_h_nxt;
  logic                              match;
  logic [CNT_W-1:0]                  k_plus1;

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail_r] <= req.entry;
    end
    rd_data_r <= mem[scan_ptr_r];
    if (req.search) begin
      serial_r <= req.entry.serial;
    end
    hit_w_r <= hit_w_nxt;
    hit_h_r <= hit_h_nxt;
  end

  // the one serial comparator, reused for every entry
  assign match   = (rd_data_r.serial == serial_r);
  assign k_plus1 = CNT_W'(k_r) + CNT_W'(1);

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    scan_ptr_nxt = scan_ptr_r;
    k_nxt        = k_r;
    count_nxt    = count_r;
    done_nxt     = 1'b0;
    hit_nxt      = 1'b0;
    hit_w_nxt    = hit_w_r;
    hit_h_nxt    = hit_h_r;
    unique case (state_r)
      Q_IDLE: begin
        if (req.push) begin
          tail_nxt = ptr_inc(tail_r);
          if (count_r == CNT_W'(DEPTH)) begin
            head_nxt = ptr_inc(head_r);
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end else if (req.search) begin
          if (count_r == '0) begin
            done_nxt = 1'b1;
          end else begin
            scan_ptr_nxt = head_r;
            state_nxt    = Q_FETCH;
          end
        end
      end
      Q_FETCH: begin
        scan_ptr_nxt = ptr_inc(scan_ptr_r);
        k_nxt        = '0;
        state_nxt    = Q_SCAN;
      end
      Q_SCAN: begin
        if (match) begin
          head_nxt  = scan_ptr_r;
          count_nxt = count_r - k_plus1;
          done_nxt  = 1'b1;
          hit_nxt   = 1'b1;
          hit_w_nxt = rd_data_r.width;
          hit_h_nxt = rd_data_r.height;
          state_nxt = Q_IDLE;
        end else if (k_plus1 == count_r) begin
          done_nxt  = 1'b1;
          state_nxt = Q_IDLE;
        end else begin
          k_nxt        = k_r + PTR_W'(1);
          scan_ptr_nxt = ptr_inc(scan_ptr_r);
        end
      end
      default: state_nxt = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= Q_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      scan_ptr_r <= '0;
      k_r        <= '0;
      count_r    <= '0;
      done_r     <= 1'b0;
      hit_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      k_r        <= k_nxt;
      count_r    <= count_nxt;
      done_r     <= done_nxt;
      hit_r      <= hit_nxt;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.hit    = hit_r;
  assign rsp.width  = hit_w_r;
  assign rsp.height = hit_h_r;

endmodule

// ===== design/configure_ack_tracker.sv =====
`timescale 1ns / 1ps
// configure/ack tracker top level: command decode, commit checks, result register
// depends on cfgack_pkg and cfgack_queue
//
//  channel | dir | ports                      | transaction
//  in_     | in  | tvalid tready tdata tuser  | one configure, ack or commit command
//  out_    | out | tvalid tready tdata tuser  | one result per command
//
// configure, commit and unused codes: result registered in the cycle after the transaction
// ack: queue fetch, then scan, one entry per cycle through the serial comparator
// in_tready is low while an ack search runs and while a result waits stalled
// synchronous active-low reset clears all control and size state; no clearing pass

module configure_ack_tracker #(
  parameter int QUEUE_DEPTH = cfgack_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cfgack_pkg::IN_TDATA_W-1:0]  in_tdata,   // serial, width, height, pad
  input  logic [cfgack_pkg::IN_TUSER_W-1:0]  in_tuser,   // opcode, has_buffer
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cfgack_pkg::OUT_TDATA_W-1:0] out_tdata,  // sent_serial, sent_width,
                                                         // sent_height, status,
                                                         // is_configured, acked_w, acked_h
  output logic                               out_tuser   // sent
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_ACK  = 2'b10
  } t_state_t;

  localparam int DW = cfgack_pkg::DIM_W;
  localparam int SW = cfgack_pkg::SERIAL_W;

  t_state_t              state_r, state_nxt;
  logic [DW-1:0]         last_w_r, last_h_r;
  logic [DW-1:0]         acked_w_r, acked_h_r;
  logic                  configured_r;
  logic                  out_valid_r;
  logic                  out_sent_r;
  cfgack_pkg::out_data_t out_data_r, out_data_nxt;
  logic                  out_sent_nxt;
  logic                  out_load;

  cfgack_pkg::q_req_t    q_req;
  cfgack_pkg::q_rsp_t    q_rsp;

  cfgack_pkg::opcode_t   op;
  logic [SW-1:0]         in_serial;
  logic [DW-1:0]         in_w, in_h;
  logic                  in_buf;
  logic                  accept;
  logic                  size_new;
  logic                  ack_hit;

  assign op        = cfgack_pkg::opcode_t'(in_tuser[cfgack_pkg::OPCODE_W-1:0]);
  assign in_buf    = in_tuser[cfgack_pkg::OPCODE_W];
  assign in_serial = in_tdata[SW-1:0];
  assign in_w      = in_tdata[SW+DW-1:SW];
  assign in_h      = in_tdata[SW+2*DW-1:SW+DW];

  assign in_tready = (state_r == T_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign size_new  = (in_w != last_w_r) || (in_h != last_h_r);
  assign ack_hit   = (state_r == T_ACK) && q_rsp.done && q_rsp.hit;

  assign q_req.push         = accept && (op == cfgack_pkg::OP_CONFIGURE) && size_new;
  assign q_req.search       = accept && (op == cfgack_pkg::OP_ACK);
  assign q_req.entry.serial = in_serial;
  assign q_req.entry.width  = in_w;
  assign q_req.entry.height = in_h;

  cfgack_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (q_req),
    .rsp   (q_rsp)
  );

  always_comb begin
    state_nxt                  = state_r;
    out_load                   = 1'b0;
    out_sent_nxt               = 1'b0;
    out_data_nxt               = '0;
    out_data_nxt.status        = cfgack_pkg::ST_OK;
    out_data_nxt.is_configured = configured_r;
    out_data_nxt.acked_w       = acked_w_r;
    out_data_nxt.acked_h       = acked_h_r;
    unique case (state_r)
      T_IDLE: begin
        if (accept) begin
          unique case (op)
            cfgack_pkg::OP_CONFIGURE: begin
              out_load = 1'b1;
              if (size_new) begin
                out_sent_nxt             = 1'b1;
                out_data_nxt.sent_serial = in_serial;
                out_data_nxt.sent_width  = in_w;
                out_data_nxt.sent_height = in_h;
              end
            end
            cfgack_pkg::OP_ACK: begin
              state_nxt = T_ACK;
            end
            cfgack_pkg::OP_COMMIT: begin
              out_load = 1'b1;
              priority if (!in_buf) begin
                out_data_nxt.status = cfgack_pkg::ST_NULL_BUFFER;
              end else if (!configured_r) begin
                out_data_nxt.status = cfgack_pkg::ST_NOT_ACKED;
              end else if ((in_w != acked_w_r) || (in_h != acked_h_r)) begin
                out_data_nxt.status = cfgack_pkg::ST_SIZE_MISM;
              end else begin
                out_data_nxt.status = cfgack_pkg::ST_OK;
              end
            end
            cfgack_pkg::OP_UNUSED: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      T_ACK: begin
        if (q_rsp.done) begin
          out_load  = 1'b1;
          state_nxt = T_IDLE;
          if (q_rsp.hit) begin
            out_data_nxt.is_configured = 1'b1;
            out_data_nxt.acked_w       = q_rsp.width;
            out_data_nxt.acked_h       = q_rsp.height;
          end else begin
            out_data_nxt.status = cfgack_pkg::ST_BAD_SERIAL;
          end
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_sent_r <= out_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      out_valid_r  <= 1'b0;
      last_w_r     <= '0;
      last_h_r     <= '0;
      acked_w_r    <= '0;
      acked_h_r    <= '0;
      configured_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_req.push) begin
        last_w_r <= in_w;
        last_h_r <= in_h;
      end
      if (ack_hit) begin
        acked_w_r    <= q_rsp.width;
        acked_h_r    <= q_rsp.height;
        configured_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sent_r;

endmodule

// ===== design/cfgack_checker.sv =====
`timescale 1ns / 1ps
// port-level checks for the configure/ack tracker, bound to the top level
// depends on cfgack_pkg and configure_ack_tracker

module cfgack_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [cfgack_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [cfgack_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [cfgack_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                               out_tuser
);

  cfgack_pkg::out_data_t od;
  assign od = out_tdata;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // no new command while a result sits stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !(out_tvalid && !out_tready))
    else $error("command taken while result stalled");

  // issued configure always reports ok
  a_sent_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> od.status == cfgack_pkg::ST_OK)
    else $error("issued configure with error status");

  // nothing issued means zero configure fields
  a_unsent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      od.sent_serial == '0 && od.sent_width == '0 && od.sent_height == '0)
    else $error("configure fields set without issue");

  // commit before first ack only while unconfigured
  a_not_acked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && od.status == cfgack_pkg::ST_NOT_ACKED |-> !od.is_configured)
    else $error("commit-before-ack reported while configured");

endmodule

bind configure_ack_tracker cfgack_checker u_cfgack_checker (.*);

// ===== sim/configure_ack_tracker_checker.sv =====
`timescale 1ns / 1ps
// result checker for configure_ack_tracker: watches both channels, tracks the pending queue
// and compares each result transaction field by field; depends on cfgack_pkg

module configure_ack_tracker_checker
  import cfgack_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // serial, width, height, pad
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // opcode, has_buffer
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // sent_serial, sent_width, sent_height, status,
                                             // is_configured, acked_w, acked_h
  input  logic                   out_tuser,  // sent
  output int                     error_count,
  output int                     awaited_count,
  output int                     issued_count,
  output int                     matched_count
);

  typedef struct {
    logic      sent;
    out_data_t data;
  } tracker_result_t;

  entry_t           pending_cfgs[$];
  tracker_result_t  awaited_results[$];
  logic [DIM_W-1:0] last_sent_w, last_sent_h;
  logic [DIM_W-1:0] acked_w_q, acked_h_q;
  logic             configured_q;

  assign awaited_count = awaited_results.size();

  initial begin
    error_count   = 0;
    issued_count  = 0;
    matched_count = 0;
  end

  function automatic tracker_result_t predict_tracker_result(
    input opcode_t op, input logic [SERIAL_W-1:0] serial,
    input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h, input logic has_buf);
    tracker_result_t r;
    entry_t          e;
    int              k;
    int              hit_at;
    r.sent = 1'b0;
    r.data = '0;
    r.data.status = ST_OK;
    hit_at = -1;
    case (op)
      OP_CONFIGURE: begin
        if (!(w == last_sent_w && h == last_sent_h)) begin
          last_sent_w = w;
          last_sent_h = h;
          while (pending_cfgs.size() >= QUEUE_DEPTH) void'(pending_cfgs.pop_front());
          e.serial = serial;
          e.width  = w;
          e.height = h;
          pending_cfgs.push_back(e);
          r.sent = 1'b1;
          r.data.sent_serial = serial;
          r.data.sent_width  = w;
          r.data.sent_height = h;
          issued_count++;
        end
      end
      OP_ACK: begin
        for (k = 0; k < pending_cfgs.size(); k++) begin
          if (hit_at < 0 && pending_cfgs[k].serial == serial) hit_at = k;
        end
        if (hit_at < 0) begin
          r.data.status = ST_BAD_SERIAL;
        end else begin
          acked_w_q    = pending_cfgs[hit_at].width;
          acked_h_q    = pending_cfgs[hit_at].height;
          configured_q = 1'b1;
          for (k = 0; k <= hit_at; k++) void'(pending_cfgs.pop_front());
          matched_count++;
        end
      end
      OP_COMMIT: begin
        if (!has_buf) r.data.status = ST_NULL_BUFFER;
        else if (!configured_q) r.data.status = ST_NOT_ACKED;
        else if (w != acked_w_q || h != acked_h_q) r.data.status = ST_SIZE_MISM;
      end
      default: ;
    endcase
    r.data.is_configured = configured_q;
    r.data.acked_w       = acked_w_q;
    r.data.acked_h       = acked_h_q;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [SERIAL_W-1:0] exp_v,
                             input logic [SERIAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t ns: %s expected 0x%0h, actual 0x%0h", $time, fname, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    tracker_result_t exp_r;
    out_data_t       act;
    if (!rst_n) begin
      pending_cfgs.delete();
      awaited_results.delete();
      last_sent_w  = '0;
      last_sent_h  = '0;
      acked_w_q    = '0;
      acked_h_q    = '0;
      configured_q = 1'b0;
    end else begin
      // result side first: a result never belongs to the command taken at the same edge
      if (out_tvalid && out_tready) begin
        act = out_data_t'(out_tdata);
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t ns: result transaction with none expected, actual tdata 0x%0h",
                   $time, out_tdata);
        end else begin
          exp_r = awaited_results.pop_front();
          check_field("sent", SERIAL_W'(exp_r.sent), SERIAL_W'(out_tuser));
          check_field("sent_serial", exp_r.data.sent_serial, act.sent_serial);
          check_field("sent_width", SERIAL_W'(exp_r.data.sent_width),
                      SERIAL_W'(act.sent_width));
          check_field("sent_height", SERIAL_W'(exp_r.data.sent_height),
                      SERIAL_W'(act.sent_height));
          check_field("status", SERIAL_W'(exp_r.data.status), SERIAL_W'(act.status));
          check_field("is_configured", SERIAL_W'(exp_r.data.is_configured),
                      SERIAL_W'(act.is_configured));
          check_field("acked_w", SERIAL_W'(exp_r.data.acked_w), SERIAL_W'(act.acked_w));
          check_field("acked_h", SERIAL_W'(exp_r.data.acked_h), SERIAL_W'(act.acked_h));
        end
      end
      if (in_tvalid && in_tready) begin
        awaited_results.push_back(predict_tracker_result(
          opcode_t'(in_tuser[OPCODE_W-1:0]),
          in_tdata[SERIAL_W-1:0],
          in_tdata[SERIAL_W +: DIM_W],
          in_tdata[SERIAL_W + DIM_W +: DIM_W],
          in_tuser[OPCODE_W]));
      end
    end
  end

endmodule

// ===== sim/configure_ack_tracker_tb.sv =====
`timescale 1ns / 1ps
// testbench top for configure_ack_tracker: clock, reset, command stimulus and verdict
// depends on cfgack_pkg, configure_ack_tracker and configure_ack_tracker_checker

module configure_ack_tracker_tb;
  import cfgack_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_MIX = 284;
  localparam int HISTORY_MAX = 12;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // serial, width, height, pad
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // opcode, has_buffer
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // sent_serial, sent_width, sent_height, status,
                                           // is_configured, acked_w, acked_h
  logic                   out_tuser;       // sent

  int error_count, awaited_count, issued_count, matched_count;
  int tx_idle_pct = 24;
  int rx_stall_pct = 73;
  int quiet_cycles = 0;
  int n_cfg = 0, n_ack = 0, n_commit = 0, n_unused = 0;
  int total_errors;

  entry_t              cfg_history[$];
  logic [SERIAL_W-1:0] next_serial = 32'h100;
  logic [DIM_W-1:0]    last_cfg_w = '0, last_cfg_h = '0;
  logic [DIM_W-1:0]    guess_w = '0, guess_h = '0;

  configure_ack_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  configure_ack_tracker_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .awaited_count (awaited_count),
    .issued_count  (issued_count),
    .matched_count (matched_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_command(input opcode_t op, input logic [SERIAL_W-1:0] serial,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic has_buf);
    entry_t e;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, h, w, serial};
    in_tuser  <= {has_buf, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (op)
      OP_CONFIGURE: begin
        n_cfg++;
        e.serial = serial;
        e.width  = w;
        e.height = h;
        cfg_history.push_back(e);
        if (cfg_history.size() > HISTORY_MAX) void'(cfg_history.pop_front());
        last_cfg_w = w;
        last_cfg_h = h;
      end
      OP_ACK:    n_ack++;
      OP_COMMIT: n_commit++;
      default:   n_unused++;
    endcase
  endtask

  // mostly configure/ack/commit sequences that follow each other, with some noise
  task automatic send_random_command();
    int                  pick;
    int                  idx;
    logic [SERIAL_W-1:0] ser;
    logic [DIM_W-1:0]    w, h;
    logic                hb;
    pick = $urandom_range(99);
    hb   = ($urandom_range(9) != 0);
    w    = DIM_W'($urandom_range(32767));
    h    = DIM_W'($urandom_range(32767));
    ser  = $urandom;
    if (pick < 40) begin
      idx = $urandom_range(99);
      if (idx < 15) begin
        w = last_cfg_w;
        h = last_cfg_h;
      end else if (idx < 60) begin
        w = DIM_W'($urandom_range(3));
        h = DIM_W'($urandom_range(3));
      end
      idx = $urandom_range(99);
      if (idx < 85) begin
        ser = next_serial;
        next_serial++;
      end else if (idx < 92 && cfg_history.size() > 0) begin
        ser = cfg_history[$urandom_range(cfg_history.size() - 1)].serial;
      end
      send_command(OP_CONFIGURE, ser, w, h, hb);
    end else if (pick < 70) begin
      if ($urandom_range(99) < 80 && cfg_history.size() > 0) begin
        idx     = $urandom_range(cfg_history.size() - 1);
        ser     = cfg_history[idx].serial;
        guess_w = cfg_history[idx].width;
        guess_h = cfg_history[idx].height;
      end
      send_command(OP_ACK, ser, w, h, hb);
    end else if (pick < 95) begin
      if ($urandom_range(99) < 70) begin
        w = guess_w;
        h = guess_h;
      end
      send_command(OP_COMMIT, ser, w, h, hb);
    end else begin
      send_command(OP_UNUSED, ser, w, h, hb);
    end
  endtask

  initial begin
    int mix;
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // commit checks before any ack, zero size right after reset, unknown serial, spare code
    send_command(OP_COMMIT, 32'h0, 15'd5, 15'd5, 1'b1);
    send_command(OP_COMMIT, 32'h0, 15'd5, 15'd5, 1'b0);
    send_command(OP_CONFIGURE, 32'h11, 15'd0, 15'd0, 1'b1);
    send_command(OP_ACK, 32'h11, 15'd0, 15'd0, 1'b0);
    send_command(OP_UNUSED, 32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF, 1'b1);
    // ten configures, nine of them issued, overflow the queue; all-ones serial appears twice
    send_command(OP_CONFIGURE, 32'h0, 15'd1, 15'd1, 1'b0);
    send_command(OP_CONFIGURE, 32'h1, 15'h7FFF, 15'd0, 1'b0);
    send_command(OP_CONFIGURE, 32'hFFFF_FFFF, 15'd0, 15'h7FFF, 1'b1);
    send_command(OP_CONFIGURE, 32'h3, 15'h7FFF, 15'h7FFF, 1'b0);
    send_command(OP_CONFIGURE, 32'h4, 15'd2, 15'd3, 1'b0);
    send_command(OP_CONFIGURE, 32'hFFFF_FFFF, 15'd640, 15'd480, 1'b0);
    send_command(OP_CONFIGURE, 32'h6, 15'd7, 15'd7, 1'b0);
    send_command(OP_CONFIGURE, 32'h7, 15'd8, 15'd8, 1'b0);
    send_command(OP_CONFIGURE, 32'h8, 15'd9, 15'd9, 1'b0);
    send_command(OP_CONFIGURE, 32'h9, 15'd9, 15'd9, 1'b0);
    // dropped serial, then duplicate serial where the oldest entry must win
    send_command(OP_ACK, 32'h0, 15'd0, 15'd0, 1'b0);
    send_command(OP_ACK, 32'hFFFF_FFFF, 15'd0, 15'd0, 1'b0);
    send_command(OP_COMMIT, 32'h0, 15'd0, 15'h7FFF, 1'b1);
    send_command(OP_COMMIT, 32'h0, 15'd1, 15'h7FFF, 1'b1);
    send_command(OP_COMMIT, 32'h0, 15'd0, 15'd0, 1'b1);
    send_command(OP_COMMIT, 32'h0, 15'd0, 15'h7FFF, 1'b0);
    send_command(OP_ACK, 32'h8, 15'd0, 15'd0, 1'b0);

    for (mix = 0; mix < 3; mix++) begin
      if (mix == 1) begin
        tx_idle_pct  = 73;
        rx_stall_pct = 24;
      end else if (mix == 2) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      for (n = 0; n < RANDOM_PER_MIX; n++) send_random_command();
    end
    in_tvalid <= 1'b0;

    while (awaited_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    total_errors = error_count;
    if (awaited_count != 0) begin
      total_errors++;
      $display("%0t ns: %0d result transactions never arrived", $time, awaited_count);
    end
    $display("sent %0d commands: %0d configure, %0d ack, %0d commit, %0d unused code",
             n_cfg + n_ack + n_commit + n_unused, n_cfg, n_ack, n_commit, n_unused);
    $display("%0d configures issued, %0d acks matched, over three idle/stall mixes",
             issued_count, matched_count);
    if (total_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== configure_ack_tracker.f =====
design/cfgack_pkg.sv
design/cfgack_queue.sv
design/configure_ack_tracker.sv
design/cfgack_checker.sv
sim/configure_ack_tracker_checker.sv
sim/configure_ack_tracker_tb.sv
